// File: rtl/iesf_pkg.sv
// Package for the Ising spin flip unit: lattice sizes, command codes,
// item and control types, and index helper functions.
// No dependencies.
package iesf_pkg;

	localparam int SIDE    = 4;
	localparam int COORD_W = 2;
	localparam int NSITES  = SIDE * SIDE * SIDE;
	localparam int SITE_W  = $clog2(NSITES);
	localparam int MAXBOND = 3 * NSITES;
	localparam int UPBINS  = NSITES + 1;
	localparam int HDEPTH  = (MAXBOND + 1) * UPBINS;
	localparam int HADDR_W = $clog2(HDEPTH);
	localparam int WADDR_W = $clog2(MAXBOND + 1);
	localparam int BOND_W  = 8;
	localparam int UP_W    = 7;
	localparam int WT_W    = 24;
	localparam int LNU_W   = 19;
	localparam int BIN_W   = 32;
	localparam int CMD_W   = 3;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 48;

	localparam logic [CMD_W-1:0] CMD_FLIP  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WSPIN = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WWT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SETC  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RDBIN = 3'd4;

	localparam logic [BIN_W-1:0] BIN_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic [COORD_W-1:0]        x;
		logic [COORD_W-1:0]        y;
		logic [COORD_W-1:0]        z;
		logic signed [LNU_W-1:0]   lnu;
		logic                      spin_up;
		logic [BOND_W-1:0]         bond_index;
		logic [UP_W-1:0]           up_index;
		logic signed [WT_W-1:0]    weight_value;
	} item_t;

	typedef struct packed {
		logic       load;
		logic       spin_wr;
		logic       wt_wr;
		logic       set_cnt;
		logic       bin_rd;
		logic       bin_clr;
		logic       spin_rd;
		logic [1:0] rd_pair;
		logic       spin_cap;
		logic [1:0] cap_pair;
		logic       calc;
		logic       wt_rd;
		logic       decide;
		logic       hist_inc;
		logic       out_load;
		logic       clr;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             out_busy;
		logic             clr_last;
	} sts_t;

	function automatic logic [SITE_W-1:0] site_of(input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		return SITE_W'((int'(x) * SIDE + int'(y)) * SIDE + int'(z));
	endfunction

	function automatic logic [COORD_W-1:0] coord_inc(input logic [COORD_W-1:0] c);
		return (int'(c) == SIDE - 1) ? '0 : COORD_W'(int'(c) + 1);
	endfunction

	function automatic logic [COORD_W-1:0] coord_dec(input logic [COORD_W-1:0] c);
		return (c == '0) ? COORD_W'(SIDE - 1) : COORD_W'(int'(c) - 1);
	endfunction

	function automatic logic [HADDR_W-1:0] hist_addr(input logic [BOND_W-1:0] n,
		input logic [UP_W-1:0] u);
		return HADDR_W'(int'(n) * UPBINS + int'(u));
	endfunction

endpackage

// File: rtl/iesf_dp.sv
// Datapath of the Ising spin flip unit: spin, weight and histogram memories,
// count registers, acceptance compare and output register.
// Depends on iesf_pkg.
module iesf_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  iesf_pkg::ctl_t             ctl,
	output iesf_pkg::sts_t             sts,
	input  logic [iesf_pkg::IN_W-1:0]  s_axis_tdata,
	input  logic [iesf_pkg::CMD_W-1:0] s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [iesf_pkg::OUT_W-1:0] m_axis_tdata
);
	import iesf_pkg::*;

	logic                spin_mem [0:NSITES-1];
	logic [WT_W-1:0]     wt_mem   [0:MAXBOND];
	logic [BIN_W-1:0]    hist_mem [0:HDEPTH-1];

	item_t               item_q;
	logic [BOND_W-1:0]   bond_q;
	logic [UP_W-1:0]     up_q;
	logic [HADDR_W-1:0]  clr_q;
	logic                sa_q, sb_q;
	logic [7:0]          nb_q;
	logic [BOND_W-1:0]   n2_q;
	logic [UP_W-1:0]     u2_q;
	logic [WT_W-1:0]     wa_q, wb_q;
	logic                acc_q;
	logic [BIN_W-1:0]    hrd_q;
	logic [HADDR_W-1:0]  haddr_q;
	logic                bin_ok_q;
	logic                out_valid_q;
	logic [OUT_W-1:0]    out_q;

	logic [COORD_W-1:0]  xp, xm, yp, ym, zp, zm;
	logic [SITE_W-1:0]   ra, rb, ctr;
	logic [2:0]          agree;
	logic signed [9:0]   n2_c;
	logic [BOND_W-1:0]   n2_cl;
	logic [UP_W-1:0]     u2_cl;
	logic signed [WT_W:0] diff;
	logic signed [WT_W:0] lnu_e;
	logic                acc_c;
	logic [HADDR_W-1:0]  hra;
	logic                bin_ok_c;
	logic                sp_we;
	logic [SITE_W-1:0]   sp_wa;
	logic                sp_wd;
	logic                h_we;
	logic [HADDR_W-1:0]  h_wa;
	logic [BIN_W-1:0]    h_wd;
	logic                o_acc;
	logic [BIN_W-1:0]    o_bin;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			item_q.cmd          <= s_axis_tuser;
			item_q.x            <= s_axis_tdata[1:0];
			item_q.y            <= s_axis_tdata[3:2];
			item_q.z            <= s_axis_tdata[5:4];
			item_q.lnu          <= s_axis_tdata[24:6];
			item_q.spin_up      <= s_axis_tdata[25];
			item_q.bond_index   <= s_axis_tdata[33:26];
			item_q.up_index     <= s_axis_tdata[40:34];
			item_q.weight_value <= s_axis_tdata[64:41];
		end
	end

	assign xp  = coord_inc(item_q.x);
	assign xm  = coord_dec(item_q.x);
	assign yp  = coord_inc(item_q.y);
	assign ym  = coord_dec(item_q.y);
	assign zp  = coord_inc(item_q.z);
	assign zm  = coord_dec(item_q.z);
	assign ctr = site_of(item_q.x, item_q.y, item_q.z);

	always_comb begin
		unique case (ctl.rd_pair)
			2'd0: begin ra = ctr;                          rb = site_of(xp, item_q.y, item_q.z); end
			2'd1: begin ra = site_of(xm, item_q.y, item_q.z); rb = site_of(item_q.x, yp, item_q.z); end
			2'd2: begin ra = site_of(item_q.x, ym, item_q.z); rb = site_of(item_q.x, item_q.y, zp); end
			default: begin ra = site_of(item_q.x, item_q.y, zm); rb = ctr; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.spin_rd) begin
			sa_q <= spin_mem[ra];
			sb_q <= spin_mem[rb];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.spin_cap) begin
			nb_q[{ctl.cap_pair, 1'b0}] <= sa_q;
			nb_q[{ctl.cap_pair, 1'b1}] <= sb_q;
		end
	end

	always_comb begin
		agree = '0;
		for (int i = 1; i <= 6; i++)
			agree = agree + 3'(nb_q[i] == nb_q[0]);
	end

	always_comb begin
		n2_c = $signed({2'b00, bond_q}) + 10'sd6 - $signed({5'b0, agree, 1'b0});
		if (n2_c < 0)
			n2_cl = '0;
		else if (n2_c > 10'(MAXBOND))
			n2_cl = BOND_W'(MAXBOND);
		else
			n2_cl = n2_c[BOND_W-1:0];
		if (nb_q[0])
			u2_cl = (up_q == '0) ? '0 : up_q - 1'b1;
		else
			u2_cl = (up_q >= UP_W'(NSITES)) ? UP_W'(NSITES) : up_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			n2_q <= n2_cl;
			u2_q <= u2_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wt_wr && int'(item_q.bond_index) <= MAXBOND)
			wt_mem[item_q.bond_index] <= item_q.weight_value;
	end

	always_ff @(posedge clk) begin
		if (ctl.wt_rd) begin
			wa_q <= wt_mem[bond_q];
			wb_q <= wt_mem[n2_q];
		end
	end

	assign diff  = $signed({wa_q[WT_W-1], wa_q}) - $signed({wb_q[WT_W-1], wb_q});
	assign lnu_e = {{(WT_W + 1 - LNU_W){item_q.lnu[LNU_W-1]}}, item_q.lnu};
	assign acc_c = lnu_e <= diff;

	assign bin_ok_c = int'(item_q.bond_index) <= MAXBOND && int'(item_q.up_index) <= NSITES;
	assign hra = ctl.bin_rd ? hist_addr(item_q.bond_index, item_q.up_index) :
		(acc_c ? hist_addr(n2_q, u2_q) : hist_addr(bond_q, up_q));

	always_ff @(posedge clk) begin
		if (ctl.decide || ctl.bin_rd) begin
			hrd_q   <= hist_mem[hra];
			haddr_q <= hra;
		end
		if (ctl.bin_rd)
			bin_ok_q <= bin_ok_c;
		if (ctl.decide)
			acc_q <= acc_c;
	end

	always_comb begin
		h_we = 1'b0;
		h_wa = haddr_q;
		h_wd = '0;
		priority if (ctl.clr) begin
			h_we = 1'b1;
			h_wa = clr_q;
		end else if (ctl.hist_inc) begin
			h_we = 1'b1;
			h_wd = (hrd_q == BIN_MAX) ? hrd_q : hrd_q + 1'b1;
		end else if (ctl.bin_clr) begin
			h_we = bin_ok_q;
		end
	end

	always_ff @(posedge clk) begin
		if (h_we)
			hist_mem[h_wa] <= h_wd;
	end

	always_comb begin
		sp_we = 1'b0;
		sp_wa = ctr;
		sp_wd = 1'b0;
		priority if (ctl.clr) begin
			sp_we = int'(clr_q) < NSITES;
			sp_wa = clr_q[SITE_W-1:0];
		end else if (ctl.spin_wr) begin
			sp_we = 1'b1;
			sp_wd = item_q.spin_up;
		end else if (ctl.decide) begin
			sp_we = acc_c;
			sp_wd = ~nb_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (sp_we)
			spin_mem[sp_wa] <= sp_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bond_q <= '0;
			up_q   <= '0;
			clr_q  <= '0;
		end else begin
			if (ctl.clr)
				clr_q <= clr_q + 1'b1;
			if (ctl.set_cnt) begin
				bond_q <= (int'(item_q.bond_index) > MAXBOND) ? BOND_W'(MAXBOND) :
					item_q.bond_index;
				up_q <= (int'(item_q.up_index) > NSITES) ? UP_W'(NSITES) : item_q.up_index;
			end else if (ctl.decide && acc_c) begin
				bond_q <= n2_q;
				up_q   <= u2_q;
			end
		end
	end

	assign o_acc = (item_q.cmd == CMD_FLIP) && acc_q;
	assign o_bin = ((item_q.cmd == CMD_RDBIN) && bin_ok_q) ? hrd_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.out_load)
			out_q <= {o_bin, up_q, bond_q, o_acc};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign sts.cmd      = item_q.cmd;
	assign sts.out_busy = out_valid_q && !m_axis_tready;
	assign sts.clr_last = clr_q == HADDR_W'(HDEPTH - 1);

endmodule

// File: rtl/iesf_ctrl.sv
// Controller of the Ising spin flip unit: clearing pass, command dispatch
// and the flip sequence. Depends on iesf_pkg.
module iesf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  iesf_pkg::sts_t sts,
	output iesf_pkg::ctl_t ctl
);
	import iesf_pkg::*;

	localparam logic [3:0] ST_CLR  = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_DISP = 4'd2;
	localparam logic [3:0] ST_SPIN = 4'd3;
	localparam logic [3:0] ST_NEW  = 4'd4;
	localparam logic [3:0] ST_WRD  = 4'd5;
	localparam logic [3:0] ST_DEC  = 4'd6;
	localparam logic [3:0] ST_HINC = 4'd7;
	localparam logic [3:0] ST_BCLR = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	assign s_axis_tready = state_q == ST_IDLE;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		ctl          = '0;
		ctl.rd_pair  = cnt_q[1:0];
		ctl.cap_pair = 2'(cnt_q - 3'd1);
		unique case (state_q)
			ST_CLR: begin
				ctl.clr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				ctl.load = s_axis_tvalid;
				if (s_axis_tvalid)
					state_d = ST_DISP;
			end
			ST_DISP: begin
				state_d = ST_OUT;
				unique case (sts.cmd)
					CMD_FLIP: begin
						state_d = ST_SPIN;
						cnt_d   = '0;
					end
					CMD_WSPIN: ctl.spin_wr = 1'b1;
					CMD_WWT:   ctl.wt_wr   = 1'b1;
					CMD_SETC:  ctl.set_cnt = 1'b1;
					CMD_RDBIN: begin
						ctl.bin_rd = 1'b1;
						state_d    = ST_BCLR;
					end
					default: ;
				endcase
			end
			ST_SPIN: begin
				ctl.spin_rd  = cnt_q != 3'd4;
				ctl.spin_cap = cnt_q != 3'd0;
				cnt_d        = cnt_q + 3'd1;
				if (cnt_q == 3'd4)
					state_d = ST_NEW;
			end
			ST_NEW: begin
				ctl.calc = 1'b1;
				state_d  = ST_WRD;
			end
			ST_WRD: begin
				ctl.wt_rd = 1'b1;
				state_d   = ST_DEC;
			end
			ST_DEC: begin
				ctl.decide = 1'b1;
				state_d    = ST_HINC;
			end
			ST_HINC: begin
				ctl.hist_inc = 1'b1;
				state_d      = ST_OUT;
			end
			ST_BCLR: begin
				ctl.bin_clr = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/ising_entropic_spin_flip_unit.sv
// Top level of the Ising flat-histogram spin flip unit.
// A flip attempt runs dispatch, spin reads, new counts, weight read, decide,
// histogram increment and output; read-and-clear bin runs dispatch, bin
// clear and output; other commands run dispatch and output. Output waits
// while the last result is stalled. Reset: clears the histogram and spins
// one entry a cycle, with tready low. Depends on iesf_pkg, iesf_ctrl, iesf_dp.
module ising_entropic_spin_flip_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// site_x, site_y, site_z, log_uniform, spin_up, bond_index, up_index,
	// weight_value, zero fill
	input  logic [iesf_pkg::IN_W-1:0]  s_axis_tdata,
	// command
	input  logic [iesf_pkg::CMD_W-1:0] s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// accepted, bond_count, up_count, bin_value
	output logic [iesf_pkg::OUT_W-1:0] m_axis_tdata
);
	import iesf_pkg::*;

	ctl_t ctl;
	sts_t sts;

	iesf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.ctl           (ctl)
	);

	iesf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: rtl/iesf_chk.sv
// Port checker for the Ising spin flip unit, bound to the top level.
// Depends on iesf_pkg.
module iesf_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_axis_tvalid,
	input logic                       s_axis_tready,
	input logic [iesf_pkg::IN_W-1:0]  s_axis_tdata,
	input logic [iesf_pkg::CMD_W-1:0] s_axis_tuser,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [iesf_pkg::OUT_W-1:0] m_axis_tdata
);
	import iesf_pkg::*;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous one at work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed under stall");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> int'(m_axis_tdata[8:1]) <= MAXBOND &&
			int'(m_axis_tdata[15:9]) <= NSITES)
		else $error("count out of range");

	a_acc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[47:16] == '0)
		else $error("accepted flip carries bin value");

endmodule

bind ising_entropic_spin_flip_unit iesf_chk u_chk (.*);
